/* sv/mft_pkg.sv */
// ----------------------------------------------------------------------------
// Multi-turn feedback tracker package
// Frame and result types and fixed constants shared by the tracker modules.
// ----------------------------------------------------------------------------
package mft_pkg;

  // One received feedback frame as it arrives at the push input.
  typedef struct packed {
    logic        bus_select;
    logic [10:0] frame_identifier;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
  } frame_t;

  // One classified frame, handed from the front to the back.
  typedef struct packed {
    logic        bus;
    logic [2:0]  slot;
    logic [15:0] angle;
    logic [15:0] speed;
    logic [15:0] current;
    logic [7:0]  temp;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic               out_bus;
    logic [2:0]         motor_slot;
    logic [15:0]        shaft_angle;
    logic signed [15:0] shaft_speed;
    logic signed [15:0] drive_current;
    logic [7:0]         temperature;
    logic signed [31:0] turn_count;
    logic signed [31:0] unwrapped_angle;
    logic               calibrating;
  } result_t;

  // Configuration register index, taken from paddr[2].
  typedef enum logic {
    REG_BASE_ID    = 1'b0,
    REG_CAL_FRAMES = 1'b1
  } reg_index_e;

  localparam int unsigned SLOT_STRIDE = 8;
  localparam int unsigned TURN_SHIFT  = 13;

  localparam logic signed [16:0] HALF_TURN = 17'sd4096;
  localparam logic [8:0]         COUNT_MAX = 9'd511;

  localparam logic [10:0] BASE_ID_RST    = 11'd513;
  localparam logic [7:0]  CAL_FRAMES_RST = 8'd50;

endpackage

/* sv/mft_fifo.sv */
// ----------------------------------------------------------------------------
// Tracker queue
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module mft_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* sv/mft_front.sv */
// ----------------------------------------------------------------------------
// Tracker front end
// Holds the configuration registers and classifies incoming frames by slot.
// ----------------------------------------------------------------------------
module mft_front
  import mft_pkg::*;
#(
  parameter int unsigned MOTOR_SLOTS = 7,
  parameter int unsigned BUS_COUNT   = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        frame_valid_i,
  input  frame_t      frame_i,
  output logic        item_valid_o,
  output item_t       item_o,
  output logic [7:0]  cal_frames_o
);

  localparam logic [10:0] SLOT_LIMIT = 11'(MOTOR_SLOTS);
  localparam logic [1:0]  BUS_LIMIT  = 2'(BUS_COUNT);

  logic [10:0] base_q, base_d;
  logic [7:0]  calf_q, calf_d;
  logic        wr_en;
  logic [10:0] diff;
  logic        hit;

  assign pready       = 1'b1;
  assign wr_en        = psel && penable && pwrite;
  assign cal_frames_o = calf_q;

  always_comb begin
    base_d = base_q;
    calf_d = calf_q;
    if (wr_en) begin
      case (paddr[2])
        REG_BASE_ID:    base_d = pwdata[10:0];
        REG_CAL_FRAMES: calf_d = pwdata[7:0];
        default:        base_d = base_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BASE_ID:    prdata = {21'b0, base_q};
      REG_CAL_FRAMES: prdata = {24'b0, calf_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_ID_RST;
      calf_q <= CAL_FRAMES_RST;
    end else begin
      base_q <= base_d;
      calf_q <= calf_d;
    end
  end

  // Drop frames outside the slot window or from a bus that is not fitted.
  assign diff = frame_i.frame_identifier - base_q;
  assign hit  = ({1'b0, frame_i.bus_select} < BUS_LIMIT)
             && (frame_i.frame_identifier >= base_q)
             && (diff < SLOT_LIMIT);

  assign item_valid_o   = frame_valid_i && hit;
  assign item_o.bus     = frame_i.bus_select;
  assign item_o.slot    = diff[2:0];
  assign item_o.angle   = {frame_i.byte0, frame_i.byte1};
  assign item_o.speed   = {frame_i.byte2, frame_i.byte3};
  assign item_o.current = {frame_i.byte4, frame_i.byte5};
  assign item_o.temp    = frame_i.byte6;

endmodule

/* sv/mft_back.sv */
// ----------------------------------------------------------------------------
// Tracker back end
// Per-slot state update (offset capture, turn counting) and total angle.
// ----------------------------------------------------------------------------
module mft_back
  import mft_pkg::*;
#(
  parameter int unsigned BUS_COUNT = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  item_t      item_i,
  output logic       item_pop_o,
  input  logic [7:0] cal_frames_i,
  output logic       res_push_o,
  output result_t    res_o,
  input  logic       res_full_i
);

  localparam int unsigned DEPTH = BUS_COUNT * SLOT_STRIDE;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic [15:0] prev_q  [DEPTH];
  logic [15:0] off_q   [DEPTH];
  logic [31:0] turns_q [DEPTH];
  logic [8:0]  cnt_q   [DEPTH];

  logic [IDX_W-1:0]   idx;
  logic               a_ready, a_fire, a_cal;
  logic [8:0]         cnt, cnt_next;
  logic [15:0]        prev, off, off_next;
  logic [31:0]        turns, turns_next;
  logic signed [16:0] delta, diff;

  logic               b_valid_q, b_valid_d;
  item_t              b_item_q;
  logic [31:0]        b_turns_q;
  logic signed [16:0] b_diff_q;
  logic               b_cal_q;

  assign res_push_o = b_valid_q && !res_full_i;
  assign a_ready    = !b_valid_q || !res_full_i;
  assign a_fire     = item_valid_i && a_ready;
  assign item_pop_o = a_fire;

  assign idx   = IDX_W'({item_i.bus, item_i.slot});
  assign prev  = prev_q[idx];
  assign off   = off_q[idx];
  assign turns = turns_q[idx];
  assign cnt   = cnt_q[idx];

  always_comb begin
    a_cal    = (cnt <= {1'b0, cal_frames_i});
    cnt_next = (cnt == COUNT_MAX) ? cnt : cnt + 9'd1;
    delta    = $signed({1'b0, item_i.angle}) - $signed({1'b0, prev});
    off_next = a_cal ? item_i.angle : off;
    diff     = $signed({1'b0, item_i.angle}) - $signed({1'b0, off_next});
    turns_next = turns;
    if (!a_cal) begin
      if (delta > HALF_TURN) begin
        turns_next = turns - 32'd1;
      end else if (delta < -HALF_TURN) begin
        turns_next = turns + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        prev_q[i]  <= '0;
        off_q[i]   <= '0;
        turns_q[i] <= '0;
        cnt_q[i]   <= '0;
      end
    end else if (a_fire) begin
      prev_q[idx]  <= item_i.angle;
      off_q[idx]   <= off_next;
      turns_q[idx] <= turns_next;
      cnt_q[idx]   <= cnt_next;
    end
  end

  always_comb begin
    b_valid_d = b_valid_q;
    if (a_fire) begin
      b_valid_d = 1'b1;
    end else if (res_push_o) begin
      b_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_item_q  <= item_i;
      b_turns_q <= turns_next;
      b_diff_q  <= diff;
      b_cal_q   <= a_cal;
    end
  end

  always_comb begin
    res_o.out_bus         = b_item_q.bus;
    res_o.motor_slot      = b_item_q.slot;
    res_o.shaft_angle     = b_item_q.angle;
    res_o.shaft_speed     = b_item_q.speed;
    res_o.drive_current   = b_item_q.current;
    res_o.temperature     = b_item_q.temp;
    res_o.turn_count      = b_turns_q;
    res_o.unwrapped_angle = {b_turns_q[31-TURN_SHIFT:0], TURN_SHIFT'(0)}
                          + {{(32-17){b_diff_q[16]}}, b_diff_q};
    res_o.calibrating     = b_cal_q;
  end

  // Hold a finished beat while the result queue is full.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && res_full_i |=> b_valid_q && $stable(b_turns_q))
    else $error("result beat lost while result queue full");

  // A calibration frame has zero angle offset, so total is whole turns only.
  a_cal_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && b_cal_q |->
      res_o.unwrapped_angle == {b_turns_q[31-TURN_SHIFT:0], TURN_SHIFT'(0)})
    else $error("calibration total angle not whole turns");

  // Tracking frames move the turn counter by at most one.
  a_turn_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_fire |-> turns_next == turns || turns_next == turns + 32'd1
            || turns_next == turns - 32'd1)
    else $error("turn counter moved by more than one");

endmodule

/* sv/motor_feedback_multiturn_tracker.sv */
// ----------------------------------------------------------------------------
// Motor feedback multi-turn tracker
// Decodes motor feedback frames, captures offsets and counts whole turns.
// ----------------------------------------------------------------------------
// Each frame does one read-modify-write of slot state in the back end.
// Throughput: one frame per cycle unless a full result queue stalls it.
// Frames outside the slot window are taken and give no result.
// Reset: config returns to 513 / 50 and all slot state clears at once.
module motor_feedback_multiturn_tracker
  import mft_pkg::*;
#(
  parameter int unsigned MOTOR_SLOTS = 7,
  parameter int unsigned BUS_COUNT   = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  frame_t      frame_i,
  output logic        empty,
  input  logic        pop,
  output result_t     result_o
);

  localparam int unsigned QUEUE_DEPTH = 2;

  logic       item_valid, item_pop, iq_empty, res_push, res_full;
  item_t      item, iq_item;
  result_t    res;
  logic [7:0] cal_frames;

  mft_front #(
    .MOTOR_SLOTS(MOTOR_SLOTS),
    .BUS_COUNT  (BUS_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frame_valid_i(push && !full),
    .frame_i      (frame_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .cal_frames_o (cal_frames)
  );

  mft_fifo #(
    .W    ($bits(item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_item_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (item_valid),
    .data_i (item),
    .full_o (full),
    .pop_i  (item_pop),
    .data_o (iq_item),
    .empty_o(iq_empty)
  );

  mft_back #(
    .BUS_COUNT(BUS_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(!iq_empty),
    .item_i      (iq_item),
    .item_pop_o  (item_pop),
    .cal_frames_i(cal_frames),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  mft_fifo #(
    .W    ($bits(result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (result_o),
    .empty_o(empty)
  );

endmodule
